// ===== sv/dmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpf_pkg
// Shared types and codes for the memory dump packet framer: configuration
// register indexes, command/status codes and the front-to-back command beat.
// ----------------------------------------------------------------------------
package dmpf_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC_WORD    = 2'd0;
  localparam logic [1:0] REG_START_ADDRESS = 2'd1;
  localparam logic [1:0] REG_DUMP_LENGTH   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Command code; doubles as the status reported on the result channel
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,   // byte sent
    OP_FAIL = 2'd1,   // read failure, no byte sent
    OP_IDLE = 2'd2    // no dump active
  } dmpf_op_t;

  // One classified input item, queued between front and back
  typedef struct packed {
    dmpf_op_t    op;
    logic [7:0]  data;
    logic        hdr;      // chunk start: emit header before the data byte
    logic        tail;     // chunk end: emit CRC after the data byte
    logic        done;     // this chunk completes the dump
    logic [31:0] address;  // chunk address for the header
    logic [15:0] length;   // chunk length for the header
  } dmpf_cmd_t;

  // Arming request from the configuration port
  typedef struct packed {
    logic        arm;
    logic [31:0] address;
    logic [31:0] length;
  } dmpf_arm_t;

endpackage

// ===== sv/dmpf_front.sv =====
// ----------------------------------------------------------------------------
// dmpf_front
// Accepts input beats, tracks chunk position, address and remaining count,
// and turns each beat into one command for the emitter.
// ----------------------------------------------------------------------------
module dmpf_front #(
  parameter int CHUNK_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dmpf_pkg::dmpf_arm_t arm,
  input  logic               in_valid,
  input  logic               in_kind,
  input  logic [7:0]         in_data_byte,
  input  logic               q_ready,
  output logic               q_push,
  output dmpf_pkg::dmpf_cmd_t q_cmd
);

  localparam int          LEN_W     = $clog2(CHUNK_BYTES + 1);
  localparam logic [31:0] CHUNK_W32 = 32'(CHUNK_BYTES);

  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic             active_r, active_nxt;
  logic [LEN_W-1:0] clen_r, clen_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  logic             hdr;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] pos_inc;
  logic             tail;
  logic             done;

  assign hdr     = (pos_r == '0);
  assign len     = hdr ? ((rem_r < CHUNK_W32) ? rem_r[LEN_W-1:0] : LEN_W'(CHUNK_BYTES))
                       : clen_r;
  assign pos_inc = pos_r + 1'b1;
  assign tail    = (pos_inc >= len);
  assign done    = tail && (rem_r == 32'(len));

  assign q_push = in_valid && q_ready;

  always_comb begin
    q_cmd         = '0;
    q_cmd.data    = in_data_byte;
    if (!active_r) begin
      q_cmd.op = dmpf_pkg::OP_IDLE;
    end else if (in_kind) begin
      q_cmd.op = dmpf_pkg::OP_FAIL;
    end else begin
      q_cmd.op      = dmpf_pkg::OP_SEND;
      q_cmd.hdr     = hdr;
      q_cmd.tail    = tail;
      q_cmd.done    = done;
      q_cmd.address = addr_r;
      q_cmd.length  = 16'(len);
    end
  end

  always_comb begin
    addr_nxt   = addr_r;
    rem_nxt    = rem_r;
    active_nxt = active_r;
    clen_nxt   = clen_r;
    pos_nxt    = pos_r;
    if (arm.arm) begin
      addr_nxt   = arm.address;
      rem_nxt    = arm.length;
      active_nxt = 1'b1;
      clen_nxt   = '0;
      pos_nxt    = '0;
    end else if (q_push && q_cmd.op == dmpf_pkg::OP_SEND) begin
      clen_nxt = len;
      if (tail) begin
        // close the chunk; advance address and count
        pos_nxt    = '0;
        addr_nxt   = addr_r + 32'(len);
        rem_nxt    = rem_r - 32'(len);
        active_nxt = !done;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rem_r    <= '0;
      active_r <= 1'b0;
      clen_r   <= '0;
      pos_r    <= '0;
    end else begin
      addr_r   <= addr_nxt;
      rem_r    <= rem_nxt;
      active_r <= active_nxt;
      clen_r   <= clen_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

// ===== sv/dmpf_queue.sv =====
// ----------------------------------------------------------------------------
// dmpf_queue
// Small command FIFO between front and back; head is shown without a pop.
// ----------------------------------------------------------------------------
module dmpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dmpf_pkg::dmpf_cmd_t push_cmd,
  output logic                push_ready,
  input  logic                pop,
  output logic                head_valid,
  output dmpf_pkg::dmpf_cmd_t head_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dmpf_pkg::dmpf_cmd_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/dmpf_back.sv =====
// ----------------------------------------------------------------------------
// dmpf_back
// Byte emitter: walks each send command through header, data and CRC bytes,
// one result beat per cycle while out_stall is low, keeping the running CRC-32.
// ----------------------------------------------------------------------------
module dmpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         magic_word,
  input  logic                q_valid,
  input  dmpf_pkg::dmpf_cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_tx_byte,
  output logic [1:0]          out_status,
  output logic                out_last,
  output logic                out_dump_done
);

  // Byte slots within one packet
  localparam logic [3:0] STEP_MAGIC = 4'd0;
  localparam logic [3:0] STEP_ADDR  = 4'd4;
  localparam logic [3:0] STEP_DATA  = 4'd10;
  localparam logic [3:0] STEP_END   = 4'd14;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  logic        started_r, started_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;

  logic        adv;
  logic        is_send;
  logic [3:0]  step_first;
  logic [3:0]  step_last;
  logic [3:0]  step;
  logic        at_end;
  logic [7:0]  byte_val;
  logic [31:0] crc_out;

  assign adv        = !out_valid_r || !out_stall;
  assign is_send    = (q_cmd.op == dmpf_pkg::OP_SEND);
  assign step_first = q_cmd.hdr ? STEP_MAGIC : STEP_DATA;
  assign step_last  = q_cmd.tail ? STEP_END : STEP_DATA;
  assign step       = started_r ? step_r : step_first;
  assign at_end     = !is_send || (step == step_last);
  assign q_pop      = adv && q_valid && at_end;
  assign crc_out    = ~crc_r;

  always_comb begin
    case (step)
      4'd0:    byte_val = magic_word[31:24];
      4'd1:    byte_val = magic_word[23:16];
      4'd2:    byte_val = magic_word[15:8];
      4'd3:    byte_val = magic_word[7:0];
      4'd4:    byte_val = q_cmd.address[31:24];
      4'd5:    byte_val = q_cmd.address[23:16];
      4'd6:    byte_val = q_cmd.address[15:8];
      4'd7:    byte_val = q_cmd.address[7:0];
      4'd8:    byte_val = q_cmd.length[15:8];
      4'd9:    byte_val = q_cmd.length[7:0];
      4'd10:   byte_val = q_cmd.data;
      4'd11:   byte_val = crc_out[31:24];
      4'd12:   byte_val = crc_out[23:16];
      4'd13:   byte_val = crc_out[15:8];
      4'd14:   byte_val = crc_out[7:0];
      default: byte_val = '0;
    endcase
  end

  always_comb begin
    started_nxt   = started_r;
    step_nxt      = step_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    tx_nxt        = tx_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (adv) begin
      out_valid_nxt = q_valid;
      if (q_valid) begin
        status_nxt = 2'(q_cmd.op);
        last_nxt   = at_end;
        done_nxt   = is_send && at_end && q_cmd.done;
        tx_nxt     = is_send ? byte_val : 8'd0;
        if (is_send) begin
          // address, length and data bytes feed the CRC; restart it at the address
          if (step inside {[STEP_ADDR:STEP_DATA]}) begin
            crc_nxt = crc_byte((step == STEP_ADDR) ? 32'd0 : crc_r, byte_val);
          end
          if (at_end) begin
            started_nxt = 1'b0;
          end else begin
            started_nxt = 1'b1;
            step_nxt    = step + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      step_r      <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      step_r      <= step_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r     <= tx_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    done_r   <= done_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_r;
  assign out_status    = status_r;
  assign out_last      = last_r;
  assign out_dump_done = done_r;

endmodule

// ===== sv/memory_dump_packet_framer.sv =====
// ----------------------------------------------------------------------------
// memory_dump_packet_framer
// Frames a stream of memory bytes into chunked dump packets: magic word,
// address, length, data and CRC-32, all big-endian, one byte per beat.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | sink      | in_valid / in_stall | in_kind, in_data_byte
//   out     | source    | out_valid/out_stall | out_tx_byte, out_status,
//           |           |                     | out_last, out_dump_done
//   cfg     | sink      | cfg_we              | cfg_index, cfg_wdata
//
// The emitter sends one result beat per cycle while out_stall is low: a
// mid-chunk data byte is a single beat, a chunk start adds ten header beats
// and a chunk end four CRC beats (up to fifteen for a one-byte chunk). Input
// beats go one per cycle, while the queue has room, into a QUEUE_DEPTH-entry
// command queue, so header and CRC bursts are absorbed there.
// Reset (rst_n, synchronous, active low) clears the configuration registers,
// the dump state, the queue and the output valid flag.
// in_stall rises only when the command queue is full; out_stall holds the
// output register and, through the queue, eventually the input.
// ----------------------------------------------------------------------------
module memory_dump_packet_framer #(
  parameter int CHUNK_BYTES = 512,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [dmpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [7:0]                    in_data_byte,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_tx_byte,
  output logic [1:0]                    out_status,
  output logic                          out_last,
  output logic                          out_dump_done
);

  logic [31:0] magic_r, magic_nxt;
  logic [31:0] start_r, start_nxt;

  dmpf_pkg::dmpf_arm_t arm;
  dmpf_pkg::dmpf_cmd_t push_cmd;
  dmpf_pkg::dmpf_cmd_t head_cmd;
  logic                q_ready;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;

  // Configuration registers; dump_length is not kept, only its arming effect
  always_comb begin
    magic_nxt = magic_r;
    start_nxt = start_r;
    if (cfg_we) begin
      case (cfg_index)
        dmpf_pkg::REG_MAGIC_WORD:    magic_nxt = cfg_wdata;
        dmpf_pkg::REG_START_ADDRESS: start_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
      start_r <= '0;
    end else begin
      magic_r <= magic_nxt;
      start_r <= start_nxt;
    end
  end

  // A nonzero dump length arms a fresh dump from the stored start address
  assign arm.arm     = cfg_we && (cfg_index == dmpf_pkg::REG_DUMP_LENGTH) && (cfg_wdata != '0);
  assign arm.address = start_r;
  assign arm.length  = cfg_wdata;

  // Hold input while the queue is full
  assign in_stall = !q_ready;

  dmpf_front #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .arm          (arm),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  dmpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  dmpf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .magic_word    (magic_r),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_status    (out_status),
    .out_last      (out_last),
    .out_dump_done (out_dump_done)
  );

endmodule
